// ===== src/rcrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrr_pkg: shared types and codes of the register cache
// Tag kinds, action codes, request codes and sequencer states.
// ----------------------------------------------------------------------------
package rcrr_pkg;

  localparam int NREGS_C     = 28;
  localparam int FIRST_REG_C = 1;
  localparam int END_REG_C   = 28;
  localparam int PREG_BASE   = 20;

  typedef enum logic [2:0] {
    K_EMPTY = 3'd0, K_GLOBAL = 3'd1, K_LOCAL = 3'd2, K_PARAM = 3'd3,
    K_CONST = 3'd4, K_AGLOBAL = 3'd5, K_ALOCAL = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    A_REG = 4'd0, A_PREG = 4'd1, A_IMM = 4'd2, A_SPILL_G = 4'd3,
    A_SPILL_L = 4'd4, A_LOAD_G = 4'd5, A_LOAD_L = 4'd6, A_LOAD_P = 4'd7,
    A_MOVE_C = 4'd8, A_ADDR_G = 4'd9, A_ADDR_L = 4'd10, A_DONE = 4'd11,
    A_ERROR = 4'd12
  } action_t;

  typedef enum logic [2:0] {
    F_USE = 3'd0, F_DEFINE = 3'd1, F_ADDR = 3'd2, F_FLUSH = 3'd3,
    F_CLRCONST = 3'd4, F_LOCK = 3'd5, F_UNLOCK = 3'd6, F_BAD = 3'd7
  } func_t;

  localparam logic [1:0] VK_GLOBAL = 2'd0;
  localparam logic [1:0] VK_LOCAL  = 2'd1;
  localparam logic [1:0] VK_PARAM  = 2'd2;
  localparam logic [1:0] VK_CONST  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_HIT, S_EMPTY, S_VICTIM, S_SPILL, S_LOAD, S_FINAL,
    S_FLUSH, S_CLR, S_DONE
  } state_t;

endpackage

// ===== src/register_cache_round_robin_spill.sv =====
// ----------------------------------------------------------------------------
// register_cache_round_robin_spill: fully associative register table
// Caches operands in registers, allocates with round-robin spill.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then walks
// its register table one entry per cycle through a single shared table read:
// a hit search, an empty search and a round-robin victim search each scan up
// to (HI - FIRST_REG) entries, HI being END_REG capped at NREGS_C, and a flush
// or constant clear visits each register once. Results come out on the result
// ports for exactly one cycle with out_valid high; the receiver cannot stall
// them, so it must take every item as it appears. last marks the final item
// of a request. Lock and unlock-all end with a single done item.
// param_count may be written whenever the block is idle.
module register_cache_round_robin_spill #(
  parameter int FIRST_REG = rcrr_pkg::FIRST_REG_C,
  parameter int END_REG   = rcrr_pkg::END_REG_C
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic [2:0]  func,
  input  logic [1:0]  var_kind,
  input  logic [9:0]  var_index,
  input  logic signed [31:0] const_value,
  input  logic        keep_const,
  input  logic        load_from_slot,
  input  logic [4:0]  lock_target,
  output logic        out_valid,
  output logic [3:0]  action,
  output logic [4:0]  reg_number,
  output logic [9:0]  var_index_res,
  output logic [10:0] slot,
  output logic signed [31:0] const_value_res,
  output logic        last
);
  import rcrr_pkg::*;

  localparam int HI = (END_REG > NREGS_C) ? NREGS_C : END_REG;
  localparam logic [4:0] LO5 = 5'(FIRST_REG);
  localparam logic [4:0] HI5 = 5'(HI);

  // register table
  logic [12:0] entry_tag [NREGS_C];
  logic [NREGS_C-1:0] entry_locked;
  logic [4:0]  victim_pointer;
  logic [3:0]  param_count;

  // latched request
  logic [2:0]  rq_func;
  logic [1:0]  rq_kind;
  logic [9:0]  rq_idx;
  logic [31:0] rq_cval;
  logic [12:0] rq_tag;
  logic [4:0]  rq_tgt;

  state_t      state, state_next;
  logic [4:0]  ptr;       // scan pointer
  logic [4:0]  cnt;       // victim scan count
  logic [4:0]  sel;       // chosen register

  // one shared compare on the entry under the pointer
  logic [12:0] cur_tag;
  logic [2:0]  cur_kind;
  logic        hit_now;
  logic [4:0]  ptr_inc;
  assign cur_tag  = entry_tag[ptr];
  assign cur_kind = cur_tag[12:10];
  assign hit_now  = (cur_tag == rq_tag);
  assign ptr_inc  = (ptr + 5'd1 >= HI5) ? LO5 : ptr + 5'd1;

  logic        spill_needed;
  assign spill_needed = (cur_kind == K_GLOBAL) || (cur_kind == K_LOCAL);

  // output register; the strobe is a toggle compared against its delayed copy
  logic        o_tog;
  logic        o_tog_d;
  logic [3:0]  o_act;
  logic [4:0]  o_reg;
  logic [9:0]  o_vidx;
  logic [10:0] o_slot;
  logic [31:0] o_cval;
  logic        o_last;

  assign busy            = (state != S_IDLE);
  assign out_valid       = o_tog ^ o_tog_d;
  assign action          = o_act;
  assign reg_number      = o_reg;
  assign var_index_res   = o_vidx;
  assign slot            = o_slot;
  assign const_value_res = o_cval;
  assign last            = o_last;

  logic [10:0] loc_slot;
  assign loc_slot = 11'(rq_idx) + 11'(param_count);

  // sequencer and datapath in one clocked block; state_next is combinational
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   state_next = S_IDLE;
      S_HIT:    state_next = S_HIT;
      S_EMPTY:  state_next = S_EMPTY;
      S_VICTIM: state_next = S_VICTIM;
      S_SPILL:  state_next = S_LOAD;
      S_LOAD:   state_next = S_FINAL;
      S_FINAL:  state_next = S_IDLE;
      S_FLUSH:  state_next = S_FLUSH;
      S_CLR:    state_next = S_CLR;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  logic [2:0] tk;
  always_comb begin
    if (func == F_ADDR) begin
      tk = (var_kind == VK_GLOBAL) ? K_AGLOBAL : K_ALOCAL;
    end else begin
      tk = (var_kind == VK_GLOBAL) ? K_GLOBAL :
           (var_kind == VK_LOCAL) ? K_LOCAL : K_PARAM;
    end
  end

  task automatic put(input logic [3:0] a, input logic [4:0] r, input logic [9:0] v,
                     input logic [10:0] s, input logic [31:0] c, input logic l);
    o_tog   <= ~o_tog;
    o_act   <= a;
    o_reg   <= r;
    o_vidx  <= v;
    o_slot  <= s;
    o_cval  <= c;
    o_last  <= l;
  endtask

  // delay the toggle so the strobe lasts exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      o_tog_d <= 1'b0;
    end else begin
      o_tog_d <= o_tog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      o_tog          <= 1'b0;
      param_count    <= '0;
      victim_pointer <= (FIRST_REG < NREGS_C) ? LO5 : 5'd0;
      entry_locked   <= '0;
      for (int i = 0; i < NREGS_C; i++) begin
        entry_tag[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        param_count <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rq_func <= func;
            rq_kind <= var_kind;
            rq_idx  <= var_index;
            rq_cval <= const_value;
            rq_tgt  <= lock_target;
            rq_tag  <= {tk, var_index};
            ptr     <= LO5;
            cnt     <= '0;
            if (func <= F_ADDR) begin
              if (var_kind == VK_PARAM && !(func == F_USE && load_from_slot)) begin
                put(A_PREG, (var_index < 10'd8) ? 5'(PREG_BASE) + var_index[4:0] : 5'd0,
                    '0, 11'(var_index), '0, 1'b1);
              end else if (var_kind == VK_CONST && keep_const) begin
                put(A_IMM, '0, '0, '0, const_value, 1'b1);
              end else if (LO5 >= HI5) begin
                put(A_ERROR, '0, '0, '0, '0, 1'b1);
              end else if (var_kind == VK_CONST) begin
                state <= S_EMPTY;
              end else begin
                state <= S_HIT;
              end
            end else begin
              unique case (func_t'(func))
                F_FLUSH:    state <= S_FLUSH;
                F_CLRCONST: state <= S_CLR;
                F_LOCK, F_UNLOCK: state <= S_DONE;
                default:    put(A_ERROR, '0, '0, '0, '0, 1'b1);
              endcase
            end
          end
        end
        S_HIT: begin
          if (hit_now) begin
            put(A_REG, ptr, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else if (ptr + 5'd1 >= HI5) begin
            ptr   <= LO5;
            state <= S_EMPTY;
          end else begin
            ptr <= ptr + 5'd1;
          end
        end
        S_EMPTY: begin
          if (cur_tag == '0) begin
            sel   <= ptr;
            state <= S_LOAD;
          end else if (ptr + 5'd1 >= HI5) begin
            ptr   <= (victim_pointer < LO5 || victim_pointer >= HI5) ? LO5
                                                                    : victim_pointer;
            state <= S_VICTIM;
          end else begin
            ptr <= ptr + 5'd1;
          end
        end
        S_VICTIM: begin
          if (!entry_locked[ptr]) begin
            sel            <= ptr;
            victim_pointer <= ptr_inc;
            state          <= S_SPILL;
          end else if (cnt + 5'd1 >= HI5 - LO5) begin
            put(A_ERROR, '0, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 5'd1;
            ptr <= ptr_inc;
          end
        end
        S_SPILL: begin
          // emit the spill of the victim at sel (ptr still points there)
          if (cur_kind == K_GLOBAL) begin
            put(A_SPILL_G, ptr, cur_tag[9:0], '0, '0, 1'b0);
          end else if (cur_kind == K_LOCAL) begin
            put(A_SPILL_L, ptr, '0, 11'(cur_tag[9:0]) + 11'(param_count), '0, 1'b0);
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (rq_kind == VK_CONST) begin
            entry_tag[sel] <= {K_CONST, 10'd0};
            put(A_MOVE_C, sel, '0, '0, rq_cval, 1'b0);
          end else begin
            entry_tag[sel] <= rq_tag;
            if (rq_func == F_USE) begin
              if (rq_kind == VK_GLOBAL) put(A_LOAD_G, sel, rq_idx, '0, '0, 1'b0);
              else if (rq_kind == VK_LOCAL) put(A_LOAD_L, sel, '0, loc_slot, '0, 1'b0);
              else put(A_LOAD_P, sel, '0, 11'(rq_idx), '0, 1'b0);
            end else if (rq_func == F_ADDR) begin
              if (rq_kind == VK_GLOBAL) put(A_ADDR_G, sel, rq_idx, '0, '0, 1'b0);
              else put(A_ADDR_L, sel, '0, loc_slot, '0, 1'b0);
            end
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          put(A_REG, sel, '0, '0, '0, 1'b1);
          state <= S_IDLE;
        end
        S_FLUSH: begin
          if (LO5 < HI5) begin
            if (spill_needed) begin
              if (cur_kind == K_GLOBAL) put(A_SPILL_G, ptr, cur_tag[9:0], '0, '0, 1'b0);
              else put(A_SPILL_L, ptr, '0, 11'(cur_tag[9:0]) + 11'(param_count), '0, 1'b0);
            end
            entry_tag[ptr] <= '0;
          end
          if (LO5 >= HI5 || ptr + 5'd1 >= HI5) begin
            state <= S_DONE;
          end else begin
            ptr <= ptr + 5'd1;
          end
        end
        S_CLR: begin
          if (LO5 < HI5 && cur_kind == K_CONST) begin
            entry_tag[ptr] <= '0;
          end
          if (LO5 >= HI5 || ptr + 5'd1 >= HI5) begin
            state <= S_DONE;
          end else begin
            ptr <= ptr + 5'd1;
          end
        end
        S_DONE: begin
          if (rq_func == F_LOCK) begin
            if (rq_tgt >= LO5 && rq_tgt < HI5) entry_locked[rq_tgt] <= 1'b1;
            put(A_DONE, rq_tgt, '0, '0, '0, 1'b1);
          end else begin
            if (rq_func == F_UNLOCK) begin
              for (int i = FIRST_REG; i < HI; i++) begin
                entry_locked[i] <= 1'b0;
              end
            end
            put(A_DONE, '0, '0, '0, '0, 1'b1);
          end
          state <= S_IDLE;
        end
        default: state <= state_next;
      endcase
    end
  end

endmodule

// ===== src/rcrr_checker.sv =====
// ----------------------------------------------------------------------------
// rcrr_checker: port-level checks of the register cache
// Watches the request and result handshake over time.
// ----------------------------------------------------------------------------
module rcrr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] action,
  input logic       last
);
  import rcrr_pkg::*;

  // a request always starts a burst or shows a result at once
  a_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || out_valid) else $error("request lost");

  // the final item leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !busy) else $error("busy after last item");

  // done and error always close a request
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == A_DONE || action == A_ERROR) |-> last)
    else $error("done or error not last");

  // no result without a request in flight
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    !$past(busy) && !$past(start) |-> !out_valid) else $error("stray item");

endmodule

bind register_cache_round_robin_spill rcrr_checker u_rcrr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .out_valid(out_valid), .action(action), .last(last)
);
